>>> src/cpu_bus_decoder_with_pad_ports_macros.svh
// ---------------------------------------------------------------------------
// CPU bus decoder assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef CPU_BUS_DECODER_WITH_PAD_PORTS_MACROS_SVH
`define CPU_BUS_DECODER_WITH_PAD_PORTS_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CBD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("%m: bus decoder check failed");

// Check that a condition implies a consequence in the same cycle.
`define CBD_ASSERT_IMPLIES(label, ante, cons) \
   `CBD_ASSERT(label, (ante) |-> (cons))

`endif

>>> src/cbd_pkg.sv
// ---------------------------------------------------------------------------
// CPU bus decoder package
// Memory map constants, target codes and the result types.
// ---------------------------------------------------------------------------
package cbd_pkg;

   // Work RAM size; must be a power of two so the mirror is a plain mask.
   localparam int RAM_BYTES = 2048;
   localparam int RAM_AW    = $clog2(RAM_BYTES);

   // Region boundaries
   localparam logic [15:0] PPU_BASE      = 16'h2000;
   localparam logic [15:0] IO_BASE       = 16'h4000;
   localparam logic [15:0] CART_BASE     = 16'h4020;
   localparam logic [15:0] ROM_LOW_BASE  = 16'h8000;
   localparam logic [15:0] ROM_HIGH_BASE = 16'hC000;

   // IO register indexes (offset from IO_BASE)
   localparam logic [4:0] REG_OAM_DMA = 5'h14;
   localparam logic [4:0] REG_PAD_ONE = 5'h16;
   localparam logic [4:0] REG_PAD_TWO = 5'h17;
   localparam logic [4:0] REG_IO_END  = 5'h18;

   // Access kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Targets
   localparam logic [2:0] TGT_RAM  = 3'd0;
   localparam logic [2:0] TGT_PPU  = 3'd1;
   localparam logic [2:0] TGT_IO   = 3'd2;
   localparam logic [2:0] TGT_PAD  = 3'd3;
   localparam logic [2:0] TGT_CART = 3'd4;
   localparam logic [2:0] TGT_ROM  = 3'd5;
   localparam logic [2:0] TGT_NONE = 3'd6;

   // Pad shifter length
   localparam logic [3:0] PAD_BITS = 4'd8;

   // Configuration registers: byte address 4*i, index in paddr[2]
   localparam int   CSR_AW        = 3;
   localparam logic CSR_LOW_BANK  = 1'b0;
   localparam logic CSR_HIGH_BANK = 1'b1;

   typedef struct packed {
      logic [7:0]  read_value;
      logic        read_from_block;
      logic [2:0]  target;
      logic [7:0]  ext_bank;
      logic [13:0] ext_offset;
      logic        ext_write;
      logic [7:0]  ext_value;
   } cbd_result_type;

   typedef struct packed {
      cbd_result_type result;
      logic           use_ram;
   } cbd_stage_type;

endpackage

>>> src/cbd_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module cbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the last read while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/cbd_csr.sv
// ---------------------------------------------------------------------------
// CPU bus decoder configuration registers
// APB-style port holding the two ROM window bank numbers.
// ---------------------------------------------------------------------------
module cbd_csr
   import cbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output logic [7:0]        low_bank,
   output logic [7:0]        high_bank
);

   logic [7:0] low_bank_ff,  low_bank_in;
   logic [7:0] high_bank_ff, high_bank_in;
   logic       wr_beat;
   logic       reg_sel;

   assign pready  = 1'b1;
   assign wr_beat = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      low_bank_in  = low_bank_ff;
      high_bank_in = high_bank_ff;
      if (wr_beat) begin
         case (reg_sel)
            CSR_LOW_BANK:  low_bank_in  = pwdata[7:0];
            CSR_HIGH_BANK: high_bank_in = pwdata[7:0];
            default:       low_bank_in  = low_bank_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_bank_ff  <= '0;
         high_bank_ff <= '0;
      end else begin
         low_bank_ff  <= low_bank_in;
         high_bank_ff <= high_bank_in;
      end
   end

   always_comb begin
      case (reg_sel)
         CSR_LOW_BANK:  prdata = {24'd0, low_bank_ff};
         CSR_HIGH_BANK: prdata = {24'd0, high_bank_ff};
         default:       prdata = '0;
      endcase
   end

   assign low_bank  = low_bank_ff;
   assign high_bank = high_bank_ff;

endmodule

>>> src/cbd_decode.sv
// ---------------------------------------------------------------------------
// CPU bus decoder address decode stage
// Decodes one access per cycle while req_ready is high, runs the work RAM and both pad shifters,
// and holds the decoded beat until the output stage takes it.
// ---------------------------------------------------------------------------
module cbd_decode
   import cbd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_kind,
   input  logic [15:0]    req_bus_address,
   input  logic [7:0]     req_write_value,
   input  logic [7:0]     req_pad_one_buttons,
   input  logic [7:0]     req_pad_two_buttons,
   input  logic [7:0]     low_bank,
   input  logic [7:0]     high_bank,
   input  logic           stage_advance,
   output logic           stage_valid,
   output cbd_result_type stage_result
);

   logic          take;
   logic          is_write;
   logic [4:0]    reg_idx;
   cbd_stage_type stage_in;
   cbd_stage_type stage_ff;
   logic          stage_valid_ff, stage_valid_in;

   logic          strobe_ff, strobe_in;
   logic [7:0]    pad_one_latched_ff, pad_one_latched_in;
   logic [7:0]    pad_two_latched_ff, pad_two_latched_in;
   logic [3:0]    pad_one_count_ff, pad_one_count_in;
   logic [3:0]    pad_two_count_ff, pad_two_count_in;

   logic          pad_one_bit, pad_two_bit;
   logic [3:0]    pad_one_count_step, pad_two_count_step;

   logic          ram_we, ram_re;
   logic [7:0]    ram_q;

   assign req_ready = !stage_valid_ff || stage_advance;
   assign take      = req_valid && req_ready;
   assign is_write  = (req_kind == KIND_WRITE);
   assign reg_idx   = req_bus_address[4:0];

   // Serial pad bits: live A while strobe is high, zero once all eight are out
   always_comb begin
      if (strobe_ff) begin
         pad_one_bit        = req_pad_one_buttons[0];
         pad_one_count_step = pad_one_count_ff;
      end else if (pad_one_count_ff >= PAD_BITS) begin
         pad_one_bit        = 1'b0;
         pad_one_count_step = pad_one_count_ff;
      end else begin
         pad_one_bit        = pad_one_latched_ff[pad_one_count_ff[2:0]];
         pad_one_count_step = pad_one_count_ff + 4'd1;
      end
      if (strobe_ff) begin
         pad_two_bit        = req_pad_two_buttons[0];
         pad_two_count_step = pad_two_count_ff;
      end else if (pad_two_count_ff >= PAD_BITS) begin
         pad_two_bit        = 1'b0;
         pad_two_count_step = pad_two_count_ff;
      end else begin
         pad_two_bit        = pad_two_latched_ff[pad_two_count_ff[2:0]];
         pad_two_count_step = pad_two_count_ff + 4'd1;
      end
   end

   always_comb begin
      stage_in           = '0;
      stage_in.result.target = TGT_NONE;
      ram_we             = 1'b0;
      ram_re             = 1'b0;
      strobe_in          = strobe_ff;
      pad_one_latched_in = pad_one_latched_ff;
      pad_two_latched_in = pad_two_latched_ff;
      pad_one_count_in   = pad_one_count_ff;
      pad_two_count_in   = pad_two_count_ff;

      if (req_bus_address < PPU_BASE) begin
         stage_in.result.target = TGT_RAM;
         if (is_write) begin
            ram_we = take;
         end else begin
            ram_re                          = take;
            stage_in.use_ram                = 1'b1;
            stage_in.result.read_from_block = 1'b1;
         end
      end else if (req_bus_address < IO_BASE) begin
         stage_in.result.target     = TGT_PPU;
         stage_in.result.ext_offset = {11'd0, req_bus_address[2:0]};
         stage_in.result.ext_write  = is_write;
         stage_in.result.ext_value  = is_write ? req_write_value : 8'd0;
      end else if (req_bus_address < CART_BASE) begin
         if (reg_idx == REG_PAD_ONE) begin
            stage_in.result.target     = TGT_PAD;
            stage_in.result.ext_offset = {9'd0, reg_idx};
            if (is_write) begin
               if (take) begin
                  strobe_in = req_write_value[0];
                  // strobe falling edge: latch both pads, restart both shifts
                  if (!req_write_value[0] && strobe_ff) begin
                     pad_one_latched_in = req_pad_one_buttons;
                     pad_two_latched_in = req_pad_two_buttons;
                     pad_one_count_in   = '0;
                     pad_two_count_in   = '0;
                  end
               end
            end else begin
               stage_in.result.read_value      = {7'd0, pad_one_bit};
               stage_in.result.read_from_block = 1'b1;
               if (take) begin
                  pad_one_count_in = pad_one_count_step;
               end
            end
         end else if (reg_idx == REG_PAD_TWO && !is_write) begin
            stage_in.result.target          = TGT_PAD;
            stage_in.result.ext_offset      = {9'd0, reg_idx};
            stage_in.result.read_value      = {7'd0, pad_two_bit};
            stage_in.result.read_from_block = 1'b1;
            if (take) begin
               pad_two_count_in = pad_two_count_step;
            end
         end else if (is_write) begin
            if (reg_idx == REG_OAM_DMA) begin
               stage_in.result.target     = TGT_PPU;
               stage_in.result.ext_offset = {9'd0, reg_idx};
               stage_in.result.ext_write  = 1'b1;
               stage_in.result.ext_value  = req_write_value;
            end else if (reg_idx < REG_IO_END) begin
               stage_in.result.target     = TGT_IO;
               stage_in.result.ext_offset = {9'd0, reg_idx};
               stage_in.result.ext_write  = 1'b1;
               stage_in.result.ext_value  = req_write_value;
            end
         end else begin
            stage_in.result.target     = TGT_IO;
            stage_in.result.ext_offset = {9'd0, reg_idx};
         end
      end else if (!is_write) begin
         if (req_bus_address < ROM_LOW_BASE) begin
            stage_in.result.target     = TGT_CART;
            stage_in.result.ext_offset = req_bus_address[13:0];
         end else begin
            stage_in.result.target     = TGT_ROM;
            stage_in.result.ext_offset = req_bus_address[13:0];
            stage_in.result.ext_bank   =
               (req_bus_address < ROM_HIGH_BASE) ? low_bank : high_bank;
         end
      end
   end

   always_comb begin
      if (take) begin
         stage_valid_in = 1'b1;
      end else if (stage_advance) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff     <= 1'b0;
         strobe_ff          <= 1'b0;
         pad_one_latched_ff <= '0;
         pad_two_latched_ff <= '0;
         pad_one_count_ff   <= '0;
         pad_two_count_ff   <= '0;
      end else begin
         stage_valid_ff     <= stage_valid_in;
         strobe_ff          <= strobe_in;
         pad_one_latched_ff <= pad_one_latched_in;
         pad_two_latched_ff <= pad_two_latched_in;
         pad_one_count_ff   <= pad_one_count_in;
         pad_two_count_ff   <= pad_two_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff <= stage_in;
      end
   end

   // Work RAM: written and read at the accept edge, read data lands with the beat
   cbd_ram #(
      .WIDTH (8),
      .DEPTH (RAM_BYTES)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_bus_address[RAM_AW-1:0]),
      .wr_data (req_write_value),
      .rd_en   (ram_re),
      .rd_addr (req_bus_address[RAM_AW-1:0]),
      .rd_data (ram_q)
   );

   always_comb begin
      stage_result = stage_ff.result;
      if (stage_ff.use_ram) begin
         stage_result.read_value = ram_q;
      end
   end

   assign stage_valid = stage_valid_ff;

endmodule

>>> src/cpu_bus_decoder_with_pad_ports.sv
// ---------------------------------------------------------------------------
// CPU bus decoder with pad ports
// Decodes CPU bus accesses, serves work RAM and pad reads, forwards the rest.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one bus access per beat (kind, address, write byte and the
//   live button states of both pads). rsp_* returns exactly one result beat
//   per access, in order: read byte, target, ROM bank, offset and forwarded
//   write. psel/penable/pwrite/paddr/pwdata set the two ROM window banks at
//   byte addresses 0 and 4; write them only while the block is idle.
//   A request is registered in the decode stage (which also carries the work
//   RAM registered read) and then in the output register before rsp_valid
//   rises. Throughput is one access per cycle while rsp_ready stays high.
//   When the receiver stalls, the output register holds its beat and the
//   decode stage keeps one more; only then does req_ready drop.
//   Reset clears the pad strobe, latches and counts, the banks and all valid
//   flags. Work RAM contents are undefined until written; no clearing pass.
// ---------------------------------------------------------------------------
module cpu_bus_decoder_with_pad_ports
   import cbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [15:0]       req_bus_address,
   input  logic [7:0]        req_write_value,
   input  logic [7:0]        req_pad_one_buttons,
   input  logic [7:0]        req_pad_two_buttons,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_value,
   output logic              rsp_read_from_block,
   output logic [2:0]        rsp_target,
   output logic [7:0]        rsp_ext_bank,
   output logic [13:0]       rsp_ext_offset,
   output logic              rsp_ext_write,
   output logic [7:0]        rsp_ext_value,
   // configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic           stage_valid;
   logic           stage_advance;
   cbd_result_type stage_result;
   logic [7:0]     low_bank, high_bank;

   cbd_result_type rsp_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   cbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .low_bank  (low_bank),
      .high_bank (high_bank)
   );

   cbd_decode u_decode (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_bus_address     (req_bus_address),
      .req_write_value     (req_write_value),
      .req_pad_one_buttons (req_pad_one_buttons),
      .req_pad_two_buttons (req_pad_two_buttons),
      .low_bank            (low_bank),
      .high_bank           (high_bank),
      .stage_advance       (stage_advance),
      .stage_valid         (stage_valid),
      .stage_result        (stage_result)
   );

   // advance the decode stage whenever the output register is free or drains
   assign stage_advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (stage_advance) begin
         rsp_valid_in = stage_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_advance && stage_valid) begin
         rsp_ff <= stage_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_value      = rsp_ff.read_value;
   assign rsp_read_from_block = rsp_ff.read_from_block;
   assign rsp_target          = rsp_ff.target;
   assign rsp_ext_bank        = rsp_ff.ext_bank;
   assign rsp_ext_offset      = rsp_ff.ext_offset;
   assign rsp_ext_write       = rsp_ff.ext_write;
   assign rsp_ext_value       = rsp_ff.ext_value;

endmodule

>>> src/cbd_checker.sv
// ---------------------------------------------------------------------------
// CPU bus decoder port checker
// Watches the top level ports for response consistency over time.
// ---------------------------------------------------------------------------
`include "cpu_bus_decoder_with_pad_ports_macros.svh"

module cbd_checker
   import cbd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_read_from_block,
   input logic [2:0]  rsp_target,
   input logic [7:0]  rsp_ext_bank,
   input logic        rsp_ext_write,
   input logic [13:0] rsp_ext_offset
);

   // a stalled beat stays put
   `CBD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
   `CBD_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_target) && $stable(rsp_ext_offset))
   // only RAM and pad reads are answered locally
   `CBD_ASSERT_IMPLIES(a_own_read, rsp_valid && rsp_read_from_block, rsp_target == TGT_RAM || rsp_target == TGT_PAD)
   // forwarded writes go to PPU or APU/IO registers only
   `CBD_ASSERT_IMPLIES(a_ext_write, rsp_valid && rsp_ext_write, rsp_target == TGT_PPU || rsp_target == TGT_IO)
   // bank is driven for ROM reads only
   `CBD_ASSERT_IMPLIES(a_bank_rom, rsp_valid && rsp_target != TGT_ROM, rsp_ext_bank == 8'd0)

endmodule

bind cpu_bus_decoder_with_pad_ports cbd_checker u_cbd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_read_from_block (rsp_read_from_block),
   .rsp_target          (rsp_target),
   .rsp_ext_bank        (rsp_ext_bank),
   .rsp_ext_write       (rsp_ext_write),
   .rsp_ext_offset      (rsp_ext_offset)
);

>>> tb/sv/cpu_bus_decoder_with_pad_ports_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CPU bus decoder with pad ports testbench
// Drives bus accesses and bank settings into the decoder and predicts each
// result beat from a memory map model held in a small scoreboard class.
// Work RAM, register mirrors, pad strobe scans and both ROM windows are
// covered, under several sender and receiver stall mixes.
// ---------------------------------------------------------------------------
module cpu_bus_decoder_with_pad_ports_tb
   import cbd_pkg::*;
();

   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASE_ACCESSES  = 325;

   // -------------------------------------------------------------------------
   // Memory map predictor and result checker
   // -------------------------------------------------------------------------
   class bus_map_scoreboard;
      logic [7:0]     work_ram [RAM_BYTES];
      logic           strobe;
      logic [7:0]     pad_one_latched;
      logic [7:0]     pad_two_latched;
      logic [3:0]     pad_one_count;
      logic [3:0]     pad_two_count;
      logic [7:0]     low_bank;
      logic [7:0]     high_bank;
      cbd_result_type expected_q[$];
      int             mismatches;
      int             results_seen;

      function void clear_state();
         strobe          = 1'b0;
         pad_one_latched = '0;
         pad_two_latched = '0;
         pad_one_count   = '0;
         pad_two_count   = '0;
         low_bank        = '0;
         high_bank       = '0;
         mismatches      = 0;
         results_seen    = 0;
      endfunction

      function logic shift_pad(logic [7:0] live, logic [7:0] latched, inout logic [3:0] count);
         logic bit_out;
         if (strobe) return live[0];
         if (count >= PAD_BITS) return 1'b0;
         bit_out = latched[count[2:0]];
         count   = count + 4'd1;
         return bit_out;
      endfunction

      function void note_access(logic kind, logic [15:0] addr, logic [7:0] val,
                                logic [7:0] p1, logic [7:0] p2);
         cbd_result_type r;
         logic [4:0]     reg_idx;
         r        = '0;
         r.target = TGT_NONE;
         reg_idx  = addr[4:0];
         if (addr < PPU_BASE) begin
            r.target = TGT_RAM;
            if (kind == KIND_WRITE) begin
               work_ram[addr[RAM_AW-1:0]] = val;
            end else begin
               r.read_value      = work_ram[addr[RAM_AW-1:0]];
               r.read_from_block = 1'b1;
            end
         end else if (addr < IO_BASE) begin
            r.target     = TGT_PPU;
            r.ext_offset = 14'(addr[2:0]);
            r.ext_write  = (kind == KIND_WRITE);
         end else if (addr < CART_BASE) begin
            if (reg_idx == REG_PAD_ONE) begin
               r.target     = TGT_PAD;
               r.ext_offset = 14'(reg_idx);
               if (kind == KIND_WRITE) begin
                  // falling strobe: latch both pads and restart the scans
                  if (!val[0] && strobe) begin
                     pad_one_latched = p1;
                     pad_two_latched = p2;
                     pad_one_count   = '0;
                     pad_two_count   = '0;
                  end
                  strobe = val[0];
               end else begin
                  r.read_value      = {7'd0, shift_pad(p1, pad_one_latched, pad_one_count)};
                  r.read_from_block = 1'b1;
               end
            end else if (reg_idx == REG_PAD_TWO && kind == KIND_READ) begin
               r.target          = TGT_PAD;
               r.ext_offset      = 14'(reg_idx);
               r.read_value      = {7'd0, shift_pad(p2, pad_two_latched, pad_two_count)};
               r.read_from_block = 1'b1;
            end else if (kind == KIND_WRITE) begin
               if (reg_idx == REG_OAM_DMA) begin
                  r.target     = TGT_PPU;
                  r.ext_offset = 14'(reg_idx);
                  r.ext_write  = 1'b1;
               end else if (reg_idx < REG_IO_END) begin
                  r.target     = TGT_IO;
                  r.ext_offset = 14'(reg_idx);
                  r.ext_write  = 1'b1;
               end
            end else begin
               r.target     = TGT_IO;
               r.ext_offset = 14'(reg_idx);
            end
         end else if (kind == KIND_READ) begin
            if (addr < ROM_LOW_BASE) begin
               r.target     = TGT_CART;
               r.ext_offset = 14'(addr - IO_BASE);
            end else begin
               r.target     = TGT_ROM;
               r.ext_bank   = (addr < ROM_HIGH_BASE) ? low_bank : high_bank;
               r.ext_offset = addr[13:0];
            end
         end
         if (r.ext_write) r.ext_value = val;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [13:0] exp_val, logic [13:0] act_val);
         if (act_val !== exp_val) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
         end
      endfunction

      function void check_result(cbd_result_type got);
         cbd_result_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with no access pending, expected none, got 0x%0h",
                     $time, got);
            return;
         end
         want = expected_q.pop_front();
         compare_field("read_value",      14'(want.read_value),      14'(got.read_value));
         compare_field("read_from_block", 14'(want.read_from_block), 14'(got.read_from_block));
         compare_field("target",          14'(want.target),          14'(got.target));
         compare_field("ext_bank",        14'(want.ext_bank),        14'(got.ext_bank));
         compare_field("ext_offset",      want.ext_offset,           got.ext_offset);
         compare_field("ext_write",       14'(want.ext_write),       14'(got.ext_write));
         compare_field("ext_value",       14'(want.ext_value),       14'(got.ext_value));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT signals
   // -------------------------------------------------------------------------
   logic              clock               = 1'b0;
   logic              reset               = 1'b1;
   logic              req_valid           = 1'b0;
   logic              req_ready;
   logic              req_kind            = KIND_READ;
   logic [15:0]       req_bus_address     = '0;
   logic [7:0]        req_write_value     = '0;
   logic [7:0]        req_pad_one_buttons = '0;
   logic [7:0]        req_pad_two_buttons = '0;
   logic              rsp_valid;
   logic              rsp_ready           = 1'b0;
   logic [7:0]        rsp_read_value;
   logic              rsp_read_from_block;
   logic [2:0]        rsp_target;
   logic [7:0]        rsp_ext_bank;
   logic [13:0]       rsp_ext_offset;
   logic              rsp_ext_write;
   logic [7:0]        rsp_ext_value;
   logic              psel                = 1'b0;
   logic              penable             = 1'b0;
   logic              pwrite              = 1'b0;
   logic [CSR_AW-1:0] paddr               = '0;
   logic [31:0]       pwdata              = '0;
   logic [31:0]       prdata;
   logic              pready;

   cpu_bus_decoder_with_pad_ports u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_bus_address     (req_bus_address),
      .req_write_value     (req_write_value),
      .req_pad_one_buttons (req_pad_one_buttons),
      .req_pad_two_buttons (req_pad_two_buttons),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_value      (rsp_read_value),
      .rsp_read_from_block (rsp_read_from_block),
      .rsp_target          (rsp_target),
      .rsp_ext_bank        (rsp_ext_bank),
      .rsp_ext_offset      (rsp_ext_offset),
      .rsp_ext_write       (rsp_ext_write),
      .rsp_ext_value       (rsp_ext_value),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   bus_map_scoreboard board;
   int                sender_idle_pct   = 0;
   int                receiver_stall_pct = 0;
   int                accesses_sent     = 0;
   int                pad_scans         = 0;
   int                broken_scans      = 0;
   int                bank_settings     = 0;
   int                cycle_count       = 0;
   bit                ram_written [RAM_BYTES];
   logic [RAM_AW-1:0] written_idx [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: stall at random and check every accepted result beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_result({rsp_read_value, rsp_read_from_block, rsp_target,
                                rsp_ext_bank, rsp_ext_offset, rsp_ext_write, rsp_ext_value});
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, board.expected_q.size());
         $display("FAIL cpu_bus_decoder_with_pad_ports");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   task automatic send_access(logic kind, logic [15:0] addr, logic [7:0] val,
                              logic [7:0] p1, logic [7:0] p2);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_kind            <= kind;
      req_bus_address     <= addr;
      req_write_value     <= val;
      req_pad_one_buttons <= p1;
      req_pad_two_buttons <= p2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_access(kind, addr, val, p1, p2);
      accesses_sent++;
      if (kind == KIND_WRITE && addr < PPU_BASE && !ram_written[addr[RAM_AW-1:0]]) begin
         ram_written[addr[RAM_AW-1:0]] = 1'b1;
         written_idx.push_back(addr[RAM_AW-1:0]);
      end
   endtask

   task automatic send_simple(logic kind, logic [15:0] addr, logic [7:0] val);
      send_access(kind, addr, val, 8'($urandom), 8'($urandom));
   endtask

   // Drop valid and hold until every pending result beat is back
   task automatic drain_bus();
      req_valid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_bank(logic index, logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {24'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (index == CSR_LOW_BANK) board.low_bank = value;
      else board.high_bank = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // idle the port between transfers
      @(posedge clock);
   endtask

   // Strobe high (skipped at random in one scan of eight), strobe low, then 6 to 20 reads of random pads
   task automatic pad_scan();
      int reads;
      int k;
      pad_scans++;
      if ($urandom_range(7) == 0) begin
         broken_scans++;
      end else begin
         send_simple(KIND_WRITE, IO_BASE + 16'(REG_PAD_ONE), {7'($urandom), 1'b1});
         reads = $urandom_range(0, 2);
         for (k = 0; k < reads; k++)
            send_simple(KIND_READ, IO_BASE + 16'($urandom_range(0, 1) ? REG_PAD_ONE : REG_PAD_TWO),
                        8'($urandom));
      end
      send_simple(KIND_WRITE, IO_BASE + 16'(REG_PAD_ONE), {7'($urandom), 1'b0});
      reads = $urandom_range(6, 20);
      for (k = 0; k < reads; k++)
         send_simple(KIND_READ, IO_BASE + 16'($urandom_range(0, 1) ? REG_PAD_ONE : REG_PAD_TWO),
                     8'($urandom));
   endtask

   task automatic random_access();
      int          pick;
      logic        kind;
      logic [15:0] addr;
      pick = $urandom_range(99);
      kind = 1'($urandom);
      if (pick < 20) begin
         send_simple(KIND_WRITE, 16'($urandom_range(0, PPU_BASE - 1)), 8'($urandom));
      end else if (pick < 40) begin
         if (written_idx.size() == 0) begin
            send_simple(KIND_WRITE, 16'($urandom_range(0, PPU_BASE - 1)), 8'($urandom));
         end else begin
            addr = 16'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
            addr = addr + 16'($urandom_range(0, 3) * RAM_BYTES);
            send_simple(KIND_READ, addr, 8'($urandom));
         end
      end else if (pick < 50) begin
         send_simple(kind, 16'($urandom_range(PPU_BASE, IO_BASE - 1)), 8'($urandom));
      end else if (pick < 60) begin
         send_simple(kind, IO_BASE + 16'($urandom_range(0, 31)), 8'($urandom));
      end else if (pick < 75) begin
         send_simple(kind, 16'($urandom_range(CART_BASE, 16'hFFFF)), 8'($urandom));
      end else if (pick < 85) begin
         addr = 16'($urandom);
         // never read RAM that was not written; turn it into a write
         if (addr < PPU_BASE && !ram_written[addr[RAM_AW-1:0]]) kind = KIND_WRITE;
         send_simple(kind, addr, 8'($urandom));
      end else begin
         pad_scan();
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int          phase;
      int          phase_end;
      logic [7:0]  low_set  [4];
      logic [7:0]  high_set [4];
      bit          paused;

      board = new();
      board.clear_state();
      low_set  = '{8'hFF, 8'h00, 8'($urandom), 8'hFF};
      high_set = '{8'h00, 8'hFF, 8'($urandom), 8'hFF};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: region edges, mirrors and the pad strobe cases
      send_simple(KIND_WRITE, 16'h0000, 8'h00);
      send_simple(KIND_WRITE, 16'h1FFF, 8'hFF);
      send_simple(KIND_READ,  16'h0000, 8'hFF);
      send_simple(KIND_READ,  16'h07FF, 8'h00);
      send_simple(KIND_READ,  16'h1800, 8'h00);
      send_simple(KIND_WRITE, PPU_BASE, 8'hA5);
      send_simple(KIND_READ,  16'h3FFF, 8'h5A);
      send_simple(KIND_WRITE, IO_BASE + 16'(REG_OAM_DMA), 8'h3C);
      send_simple(KIND_READ,  IO_BASE + 16'(REG_OAM_DMA), 8'h00);
      send_simple(KIND_WRITE, IO_BASE, 8'hFF);
      send_simple(KIND_WRITE, IO_BASE + 16'(REG_PAD_TWO), 8'hC3);
      send_simple(KIND_READ,  16'h4015, 8'h00);
      send_simple(KIND_WRITE, IO_BASE + 16'(REG_IO_END), 8'h77);
      send_simple(KIND_READ,  16'h401F, 8'h00);
      send_simple(KIND_READ,  CART_BASE, 8'h00);
      send_simple(KIND_READ,  16'h7FFF, 8'h00);
      send_simple(KIND_WRITE, CART_BASE, 8'h11);
      send_simple(KIND_READ,  ROM_LOW_BASE, 8'h00);
      send_simple(KIND_READ,  16'hBFFF, 8'h00);
      send_simple(KIND_READ,  ROM_HIGH_BASE, 8'h00);
      send_simple(KIND_READ,  16'hFFFF, 8'h00);
      send_simple(KIND_WRITE, 16'hFFFF, 8'h22);
      send_access(KIND_WRITE, IO_BASE + 16'(REG_PAD_ONE), 8'h01, 8'h00, 8'h00);
      send_access(KIND_READ,  IO_BASE + 16'(REG_PAD_ONE), 8'h00, 8'h01, 8'hFE);
      send_access(KIND_WRITE, IO_BASE + 16'(REG_PAD_ONE), 8'hFE, 8'hA5, 8'h5A);
      send_access(KIND_READ,  IO_BASE + 16'(REG_PAD_ONE), 8'h00, 8'h00, 8'h00);
      send_access(KIND_READ,  IO_BASE + 16'(REG_PAD_TWO), 8'h00, 8'hFF, 8'hFF);

      // Random phases, each under its own stall mix and bank setting
      for (phase = 0; phase < 4; phase++) begin
         drain_bus();
         write_bank(CSR_LOW_BANK,  low_set[phase]);
         write_bank(CSR_HIGH_BANK, high_set[phase]);
         bank_settings++;
         @(posedge clock);
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
            default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
         endcase
         paused    = 1'b0;
         phase_end = accesses_sent + PHASE_ACCESSES;
         while (accesses_sent < phase_end) begin
            if (phase == 2 && !paused && accesses_sent > phase_end - PHASE_ACCESSES / 2) begin
               drain_bus();
               paused = 1'b1;
            end
            random_access();
         end
      end

      req_valid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d bus accesses and %0d result beats over four stall mixes",
               accesses_sent, board.results_seen);
      $display("and %0d bank settings, with %0d pad scans (%0d without a strobe rise).",
               bank_settings, pad_scans, broken_scans);
      if (board.mismatches == 0 && board.expected_q.size() == 0) begin
         $display("PASS cpu_bus_decoder_with_pad_ports");
      end else begin
         $display("FAIL cpu_bus_decoder_with_pad_ports");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/cbd_pkg.sv
src/cbd_ram.sv
src/cbd_csr.sv
src/cbd_decode.sv
src/cpu_bus_decoder_with_pad_ports.sv
src/cbd_checker.sv
tb/sv/cpu_bus_decoder_with_pad_ports_tb.sv
